### src/spq_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the sorted priority queue.
// No dependencies; imported by spq_cell and sorted_priority_queue_core.
package spq_pkg;

  localparam int KEY_W = 16;
  localparam int TAG_W = 16;
  localparam int COUNT_W = 5;

  typedef enum logic [0:0] {
    CMD_INSERT = 1'b0,
    CMD_POP    = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  // One stored entry.
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } entry_t;

  // Operation broadcast to every cell of the row in the cycle it takes effect.
  typedef struct packed {
    logic   ins;
    logic   pop;
    entry_t fresh;
  } cell_ctl_t;

endpackage

### src/spq_cell.sv
`timescale 1ns / 1ps
// One slot of the sorted row: holds an entry and shifts it toward
// the tail on insert or toward the head on pop. Depends on spq_pkg.
module spq_cell
  import spq_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  logic      occupied,
  input  entry_t    prev_entry,
  input  logic      prev_moves,
  input  entry_t    next_entry,
  output entry_t    entry,
  output logic      moves
);

  entry_t entry_next;

  // The new entry belongs at or ahead of this slot when the slot is empty
  // or holds a strictly smaller key; the row is sorted, so these flags
  // switch from low to high at most once along the row.
  assign moves = ctl.ins && (!occupied || (ctl.fresh.key > entry.key));

  always_comb begin
    entry_next = entry;
    if (moves) begin
      entry_next = prev_moves ? prev_entry : ctl.fresh;
    end else if (ctl.pop) begin
      entry_next = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

### src/sorted_priority_queue_core.sv
`timescale 1ns / 1ps
// Top level of the sorted priority queue: a row of spq_cell slots, the
// fill counter and the response register. Depends on spq_pkg, spq_cell.
//
//   channel  valid      stall      payload
//   request  req_valid  req_stall  cmd, priority_req, tag
//   response rsp_valid  rsp_stall  status, out_priority, out_tag, count
//
// All slots compare the new key against their own entry in parallel and shift at
// the same clock edge, so one request can be accepted in every cycle unless a held
// response is stalled, and its response appears in the following cycle.
// Reset empties the queue by clearing the fill counter; slot contents are
// not cleared, since only slots below the fill level are ever used.
// The request side stalls only while a response is held and stalled, so the
// response register is the single point of backpressure.
module sorted_priority_queue_core
  import spq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic               cmd,
  input  logic [KEY_W-1:0]   priority_req,
  input  logic [TAG_W-1:0]   tag,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output logic [1:0]         status,
  output logic [KEY_W-1:0]   out_priority,
  output logic [TAG_W-1:0]   out_tag,
  output logic [COUNT_W-1:0] count
);

  localparam int FILL_W = $clog2(DEPTH + 1);

  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] fill_next;
  logic              accept;
  logic              is_full;
  logic              is_empty;
  cell_ctl_t         ctl;
  status_t           stat_next;
  entry_t            popped;
  entry_t            slot   [DEPTH];
  logic              moves  [DEPTH];
  logic [31:0]       fill_wide;

  // A new request is taken whenever the response register is free or is
  // being emptied in the same cycle.
  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;

  assign is_full  = (fill == FILL_W'(DEPTH));
  assign is_empty = (fill == '0);

  // Dropped inserts and pops on an empty queue leave the row untouched.
  assign ctl.ins   = accept && (cmd == CMD_INSERT) && !is_full;
  assign ctl.pop   = accept && (cmd == CMD_POP) && !is_empty;
  assign ctl.fresh = '{key: priority_req, tag: tag};

  always_comb begin
    fill_next = fill;
    stat_next = STAT_OK;
    popped    = '0;
    if (accept) begin
      if (cmd == CMD_INSERT) begin
        if (is_full) begin
          stat_next = STAT_FULL;
        end else begin
          fill_next = fill + FILL_W'(1);
        end
      end else begin
        if (is_empty) begin
          stat_next = STAT_EMPTY;
        end else begin
          fill_next = fill - FILL_W'(1);
          popped    = slot[0];
        end
      end
    end
  end

  // The row of slots; slot 0 is the head and holds the highest key.
  for (genvar i = 0; i < DEPTH; i++) begin : g_slot
    if (i == 0) begin : g_head
      spq_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .occupied   (FILL_W'(i) < fill),
        .prev_entry (ctl.fresh),
        .prev_moves (1'b0),
        .next_entry (slot[(i + 1) % DEPTH]),
        .entry      (slot[i]),
        .moves      (moves[i])
      );
    end else if (i == DEPTH - 1) begin : g_tail
      spq_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .occupied   (FILL_W'(i) < fill),
        .prev_entry (slot[i - 1]),
        .prev_moves (moves[i - 1]),
        .next_entry (slot[i]),
        .entry      (slot[i]),
        .moves      (moves[i])
      );
    end else begin : g_mid
      spq_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .occupied   (FILL_W'(i) < fill),
        .prev_entry (slot[i - 1]),
        .prev_moves (moves[i - 1]),
        .next_entry (slot[i + 1]),
        .entry      (slot[i]),
        .moves      (moves[i])
      );
    end
  end

  // The count field carries the low bits of the fill level.
  assign fill_wide = 32'(fill_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      fill <= fill_next;
      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status       <= stat_next;
      out_priority <= popped.key;
      out_tag      <= popped.tag;
      count        <= fill_wide[COUNT_W-1:0];
    end
  end

  // Every response reports the fill level that the row holds after it.
  a_count_tracks_fill: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (count == COUNT_W'(32'(fill))))
    else $error("response count differs from fill level");

  // A pop on an empty queue reports empty and leaves the queue empty.
  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    (accept && (cmd == CMD_POP) && is_empty) |=>
      (rsp_valid && (status == STAT_EMPTY) && (fill == '0)))
    else $error("pop on empty queue mishandled");

  // An accepted insert into a queue that is not full grows the queue by one and reports OK.
  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && (cmd == CMD_INSERT) && !is_full) |=>
      ((fill == $past(fill) + FILL_W'(1)) && (status == STAT_OK)))
    else $error("insert did not grow the queue");

  // The two entries at the head stay in descending key order.
  a_head_sorted: assert property (@(posedge clk) disable iff (rst)
    (fill >= FILL_W'(2)) |-> (slot[0].key >= slot[1].key))
    else $error("head entries out of order");

endmodule

### tb/tb_sorted_priority_queue_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for sorted_priority_queue_core: drives inserts and pops,
// predicts each response with a shadow copy of the sorted row, and compares field by field.
// Depends on spq_pkg and sorted_priority_queue_core.
module tb_sorted_priority_queue_core;
  import spq_pkg::*;

  localparam int DEPTH = 16;
  localparam int RANDOM_ITEMS = 1650;

  // One request as it waits in the backlog, and one predicted response.
  typedef struct packed {
    cmd_t             op;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } queue_req_t;

  typedef struct packed {
    status_t            status;
    logic [KEY_W-1:0]   key;
    logic [TAG_W-1:0]   tag;
    logic [COUNT_W-1:0] count;
  } queue_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_stall;
  logic               cmd = 1'b0;
  logic [KEY_W-1:0]   priority_req = '0;
  logic [TAG_W-1:0]   tag = '0;
  logic               rsp_valid;
  logic               rsp_stall = 1'b0;
  logic [1:0]         status;
  logic [KEY_W-1:0]   out_priority;
  logic [TAG_W-1:0]   out_tag;
  logic [COUNT_W-1:0] count;

  // Requests not yet offered, and responses predicted but not yet seen.
  queue_req_t    request_backlog[$];
  queue_result_t awaited_results[$];

  // Shadow of the queue contents, head at index 0, kept in descending key order.
  entry_t shadow_row[DEPTH];
  int     shadow_fill = 0;

  int   total_requests = 0;
  int   offered_requests = 0;
  int   failures = 0;
  logic req_fire = 1'b0;  // the request on the pins was taken at the last rising edge

  sorted_priority_queue_core #(.DEPTH(DEPTH)) dut (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .cmd          (cmd),
    .priority_req (priority_req),
    .tag          (tag),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .status       (status),
    .out_priority (out_priority),
    .out_tag      (out_tag),
    .count        (count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Every mismatch goes through here: one line in the log and one more in the count.
  task automatic report_mismatch(input string msg);
    failures++;
    $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  // Applies one accepted request to the shadow row and returns the response that the
  // block must give for it. A new entry goes ahead of the first stored entry with a
  // strictly smaller key, so equal keys leave in arrival order.
  function automatic queue_result_t serve_request(input cmd_t op,
                                                  input logic [KEY_W-1:0] new_key,
                                                  input logic [TAG_W-1:0] new_tag);
    queue_result_t r;
    int            slot;
    r = '0;
    r.status = STAT_OK;
    if (op == CMD_INSERT) begin
      if (shadow_fill >= DEPTH) begin
        // A full queue drops the entry and leaves the row as it was.
        r.status = STAT_FULL;
      end else begin
        slot = shadow_fill;
        for (int i = 0; i < shadow_fill; i++) begin
          if (slot == shadow_fill && new_key > shadow_row[i].key) slot = i;
        end
        for (int i = shadow_fill; i > slot; i--) shadow_row[i] = shadow_row[i-1];
        shadow_row[slot].key = new_key;
        shadow_row[slot].tag = new_tag;
        shadow_fill++;
      end
    end else if (shadow_fill == 0) begin
      r.status = STAT_EMPTY;
    end else begin
      r.key = shadow_row[0].key;
      r.tag = shadow_row[0].tag;
      for (int i = 1; i < shadow_fill; i++) shadow_row[i-1] = shadow_row[i];
      shadow_fill--;
    end
    r.count = COUNT_W'(shadow_fill);
    return r;
  endfunction

  // Idle rates by phase of the run: first the receiver holds back most of the time,
  // then the sender does, and the last third runs at full rate on both sides.
  function automatic int sender_idle_pct();
    int phase;
    phase = (total_requests == 0) ? 2 : offered_requests * 3 / total_requests;
    return (phase == 0) ? 19 : (phase == 1) ? 65 : 0;
  endfunction

  function automatic int receiver_idle_pct();
    int phase;
    phase = (total_requests == 0) ? 2 : offered_requests * 3 / total_requests;
    return (phase == 0) ? 65 : (phase == 1) ? 19 : 0;
  endfunction

  // Driver. Inputs change on the falling edge only. A new request is loaded once the
  // one on the pins has been transferred; a stalled request stays exactly as it is.
  always @(negedge clk) begin : drive_requests
    queue_req_t nxt;
    if (rst) begin
      req_valid <= 1'b0;
      rsp_stall <= 1'b0;
    end else begin
      rsp_stall <= ($urandom_range(99) < receiver_idle_pct());
      if (!req_valid || req_fire) begin
        if (request_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct()) begin
          nxt = request_backlog.pop_front();
          offered_requests++;
          req_valid    <= 1'b1;
          cmd          <= nxt.op;
          priority_req <= nxt.key;
          tag          <= nxt.tag;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor. On each rising edge it first checks a response transfer against the
  // oldest prediction, then predicts the response for a request transfer. The block
  // registers its response, so a request never answers in its own cycle.
  always @(posedge clk) begin : watch_channels
    queue_result_t want;
    if (rst) begin
      req_fire <= 1'b0;
    end else begin
      req_fire <= req_valid && !req_stall;
      if (rsp_valid && !rsp_stall) begin
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("response with nothing outstanding: status %0d count %0d",
                                    status, count));
        end else begin
          want = awaited_results.pop_front();
          if (status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", status, want.status));
          if (out_priority !== want.key)
            report_mismatch($sformatf("out_priority got %h want %h", out_priority, want.key));
          if (out_tag !== want.tag)
            report_mismatch($sformatf("out_tag got %h want %h", out_tag, want.tag));
          if (count !== want.count)
            report_mismatch($sformatf("count got %0d want %0d", count, want.count));
        end
      end
      if (req_valid && !req_stall) begin
        awaited_results.push_back(serve_request(cmd_t'(cmd), priority_req, tag));
      end
    end
  end

  task automatic queue_request(input cmd_t op, input logic [KEY_W-1:0] k,
                               input logic [TAG_W-1:0] t);
    queue_req_t r;
    r.op  = op;
    r.key = k;
    r.tag = t;
    request_backlog.push_back(r);
  endtask

  // Keys are drawn from a few pools: a narrow range to make many equal keys, the full
  // range, the extremes, and a second narrow cluster away from zero.
  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(3))
      0: return KEY_W'($urandom_range(7));
      1: return KEY_W'($urandom);
      2: begin
        case ($urandom_range(3))
          0: return 16'h0000;
          1: return 16'hFFFF;
          2: return 16'h8000;
          default: return 16'h7FFF;
        endcase
      end
      default: return KEY_W'(16'h1000 + $urandom_range(3));
    endcase
  endfunction

  initial begin : stimulus
    int produced;
    int burst_len;
    int insert_pct;
    int idx;

    // Directed part. Pop on an empty queue first, then fill the queue to capacity
    // with the extremes, equal keys and the smallest key twice so that ties and
    // tail placement show up in the pop order.
    queue_request(CMD_POP, 16'hA5A5, 16'h5A5A);
    queue_request(CMD_INSERT, 16'h1234, 16'h0001);
    queue_request(CMD_INSERT, 16'hFFFF, 16'hFFFF);
    queue_request(CMD_INSERT, 16'h0000, 16'h0002);
    queue_request(CMD_INSERT, 16'h1234, 16'h0003);
    queue_request(CMD_INSERT, 16'h0000, 16'h0004);
    queue_request(CMD_INSERT, 16'hFFFF, 16'h0005);
    queue_request(CMD_INSERT, 16'h8000, 16'h0006);
    queue_request(CMD_INSERT, 16'h7FFF, 16'h0007);
    queue_request(CMD_INSERT, 16'h5555, 16'h0008);
    queue_request(CMD_INSERT, 16'hAAAA, 16'h0009);
    queue_request(CMD_INSERT, 16'h0001, 16'h000A);
    queue_request(CMD_INSERT, 16'hFFFE, 16'h000B);
    queue_request(CMD_INSERT, 16'h1234, 16'h000C);
    queue_request(CMD_INSERT, 16'h00FF, 16'h000D);
    queue_request(CMD_INSERT, 16'hFF00, 16'h000E);
    queue_request(CMD_INSERT, 16'h1000, 16'h000F);
    // The queue is full now, so this one is dropped.
    queue_request(CMD_INSERT, 16'hABCD, 16'hBEEF);
    for (idx = 0; idx < 4; idx++) queue_request(CMD_POP, 16'hFFFF, 16'hFFFF);

    // Random part in bursts. Insert-heavy bursts drive the queue to full, pop-heavy
    // bursts drain it past empty, and balanced bursts churn entries in the middle.
    // Fields of a pop are random too, since the block must ignore them.
    produced = 0;
    while (produced < RANDOM_ITEMS) begin
      burst_len = $urandom_range(8, 40);
      case ($urandom_range(9))
        0, 1, 2, 3: insert_pct = 85;
        4, 5, 6:    insert_pct = 20;
        default:    insert_pct = 50;
      endcase
      for (idx = 0; idx < burst_len && produced < RANDOM_ITEMS; idx++) begin
        if ($urandom_range(99) < insert_pct)
          queue_request(CMD_INSERT, pick_key(), TAG_W'($urandom));
        else
          queue_request(CMD_POP, KEY_W'($urandom), TAG_W'($urandom));
        produced++;
      end
    end
    total_requests = request_backlog.size();

    // Reset is held and then released on a falling edge.
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Wait until every request has been transferred and every response has been seen,
    // then let the clock run on so that any response it should not make would be seen.
    while (request_backlog.size() != 0 || req_valid) @(negedge clk);
    while (awaited_results.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog. It ends a run that never finishes; its limit leaves a wide margin over a
  // correct run, even with the heaviest stalls on either side.
  initial begin : watchdog
    #16_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

### filelist.f
src/spq_pkg.sv
src/spq_cell.sv
src/sorted_priority_queue_core.sv
tb/tb_sorted_priority_queue_core.sv
